@@ hdl/bcm_pkg.sv @@
// Shared types and constants for the banked cartridge mapper.
// Holds the item and result structs, opcode and register codes, and FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcm_pkg;

  // Fixed geometry of the CPU side
  localparam int unsigned BANK_BYTES = 16384;
  localparam int unsigned OFF_W      = 14;     // byte offset inside a 16 KiB bank
  localparam int unsigned RAM_DEPTH  = 32768;  // two 16 KiB cart RAM banks
  localparam int unsigned RAM_AW     = 15;
  localparam int unsigned DATA_W     = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam logic [CFG_DATA_W-1:0] BANK_COUNT_RESET = 6'd32;

  // Control register bits
  localparam int unsigned CTL_RAM_BANK  = 2;   // cart RAM bank for slot 2
  localparam int unsigned CTL_RAM_SLOT2 = 3;   // cart RAM replaces slot 2
  localparam int unsigned CTL_RAM_TOP   = 4;   // cart RAM at 0xC000-0xFFFF

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_REG   = 2'd2,
    OP_LOAD  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_SLOT0   = 2'd1,
    SEL_SLOT1   = 2'd2,
    SEL_SLOT2   = 2'd3
  } regsel_e;

  // Top two address bits pick the 16 KiB region
  typedef enum logic [1:0] {
    RGN_SLOT0 = 2'd0,
    RGN_SLOT1 = 2'd1,
    RGN_SLOT2 = 2'd2,
    RGN_TOP   = 2'd3
  } region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANK_COUNT = 2'd0,
    CFG_ALT_MODE   = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_ROM  = 2'd1,
    SRC_RAM  = 2'd2
  } src_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_EXEC  = 3'd2,
    ST_READ  = 3'd3,
    ST_DIV   = 3'd4
  } state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    regsel_e     reg_select;
    logic [18:0] rom_index;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       overrides_system_ram;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/banked_cartridge_mapper_unit.sv @@
// Top level of the banked cartridge mapper: control FSM, mapper registers,
// ROM store and cart RAM memories, bank reduction unit. Uses bcm_pkg, bcm_mem, bcm_div.
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+-----------------------
//   command   | in        | start / busy               | item_i   (item_t)
//   result    | out       | done_o strobe, one cycle   | result_o (result_t)
//   config    | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Bus reads pass through EXEC (address, memory request) and READ (result from the
// registered read data); bus writes, ROM loads and control writes finish in EXEC.
// Bank writes wait in DIV on the 8-step serial remainder unit. After reset the cart
// RAM is cleared one byte a cycle, 32768 bytes, with busy high; config writes are
// always taken. Results cannot be stalled: done_o marks each one for a single cycle.
`timescale 1ns / 1ps
`default_nettype none

module banked_cartridge_mapper_unit #(
  parameter int unsigned ROM_BANKS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire bcm_pkg::item_t                item_i,
  output logic                               done_o,
  output bcm_pkg::result_t                   result_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bcm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bcm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import bcm_pkg::*;

  localparam int unsigned ROM_DEPTH = ROM_BANKS * BANK_BYTES;
  localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
  // Bank registers must also hold the reset values 1 and 2
  localparam int unsigned BANK_W    = (ROM_BANKS > 4) ? $clog2(ROM_BANKS) : 2;
  localparam logic [BANK_W:0]       ROM_BANKS_W = (BANK_W + 1)'(ROM_BANKS);
  localparam logic [DATA_W-1:0]     ROM_BANKS_B = DATA_W'(ROM_BANKS);

  state_e                state_q, state_d;
  item_t                 item_q;
  logic [DATA_W-1:0]     ctl_q, ctl_d;
  logic [BANK_W-1:0]     slot0_q, slot0_d;
  logic [BANK_W-1:0]     slot1_q, slot1_d;
  logic [BANK_W-1:0]     slot2_q, slot2_d;
  logic [CFG_DATA_W-1:0] count_q, count_d;
  logic                  alt_q, alt_d;
  logic [RAM_AW-1:0]     clr_q, clr_d;
  logic                  done_q, done_d;
  result_t               result_q, result_d;
  src_e                  src_q, src_d;

  logic              rom_en, rom_we;
  logic [ROM_AW-1:0] rom_addr;
  logic [DATA_W-1:0] rom_wdata, rom_rdata;
  logic              ram_en, ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              div_start, div_done;
  logic [DATA_W-1:0] div_divisor, div_rem;
  logic [BANK_W-1:0] new_bank;

  logic              finish;
  logic [DATA_W-1:0] rd_value;
  logic [BANK_W-1:0] rd_bank;
  logic [OFF_W-1:0]  offset;
  region_e           region;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = result_q;

  assign offset   = item_q.bus_address[OFF_W-1:0];
  assign region   = region_e'(item_q.bus_address[15:14]);
  assign new_bank = BANK_W'(div_rem);

  // Effective modulus: zero counts as one, clamp to the banks present
  always_comb begin
    if (count_q == '0) begin
      div_divisor = DATA_W'(1);
    end else if ({2'b00, count_q} > ROM_BANKS_B) begin
      div_divisor = ROM_BANKS_B;
    end else begin
      div_divisor = {2'b00, count_q};
    end
  end

  // Next state, memory requests and register updates
  always_comb begin
    state_d   = state_q;
    ctl_d     = ctl_q;
    slot0_d   = slot0_q;
    slot1_d   = slot1_q;
    slot2_d   = slot2_q;
    count_d   = count_q;
    alt_d     = alt_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    result_d  = result_q;
    src_d     = src_q;
    rom_en    = 1'b0;
    rom_we    = 1'b0;
    rom_addr  = '0;
    rom_wdata = item_q.write_data;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = item_q.write_data;
    div_start = 1'b0;
    finish    = 1'b0;
    rd_value  = '0;
    rd_bank   = '0;

    case (state_q)
      ST_CLEAR: begin
        // Sweep the cart RAM to zero after reset
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (item_q.opcode)
          OP_READ: begin
            // Decode the region and issue at most one memory read
            src_d   = SRC_ZERO;
            state_d = ST_READ;
            case (region)
              RGN_SLOT0: begin
                // First kilobyte stays on bank 0 unless the alternate mode is on
                if (item_q.bus_address[15:10] == '0 && !alt_q) begin
                  rd_bank = '0;
                end else begin
                  rd_bank = slot0_q;
                end
                src_d = SRC_ROM;
              end
              RGN_SLOT1: begin
                rd_bank = slot1_q;
                src_d   = SRC_ROM;
              end
              RGN_SLOT2: begin
                if (ctl_q[CTL_RAM_SLOT2]) begin
                  ram_en   = 1'b1;
                  ram_addr = {ctl_q[CTL_RAM_BANK], offset};
                  src_d    = SRC_RAM;
                end else begin
                  rd_bank = slot2_q;
                  src_d   = SRC_ROM;
                end
              end
              RGN_TOP: begin
                if (ctl_q[CTL_RAM_TOP]) begin
                  ram_en   = 1'b1;
                  ram_addr = {1'b0, offset};
                  src_d    = SRC_RAM;
                end
              end
              default: src_d = SRC_ZERO;
            endcase
            if (src_d == SRC_ROM) begin
              if ({1'b0, rd_bank} < ROM_BANKS_W) begin
                rom_en   = 1'b1;
                rom_addr = ROM_AW'({rd_bank, offset});
              end else begin
                src_d = SRC_ZERO;
              end
            end
          end
          OP_WRITE: begin
            // ROM slots are read-only; only mapped cart RAM takes the byte
            case (region)
              RGN_SLOT2: begin
                if (ctl_q[CTL_RAM_SLOT2]) begin
                  ram_en   = 1'b1;
                  ram_we   = 1'b1;
                  ram_addr = {ctl_q[CTL_RAM_BANK], offset};
                end
              end
              RGN_TOP: begin
                if (ctl_q[CTL_RAM_TOP]) begin
                  ram_en   = 1'b1;
                  ram_we   = 1'b1;
                  ram_addr = {1'b0, offset};
                end
              end
              default: ram_en = 1'b0;
            endcase
            finish = 1'b1;
          end
          OP_REG: begin
            if (item_q.reg_select == SEL_CONTROL) begin
              ctl_d  = item_q.write_data;
              finish = 1'b1;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
          OP_LOAD: begin
            // Drop loads beyond the store
            if (32'(item_q.rom_index) < 32'(ROM_DEPTH)) begin
              rom_en   = 1'b1;
              rom_we   = 1'b1;
              rom_addr = ROM_AW'(item_q.rom_index);
            end
            finish = 1'b1;
          end
          default: finish = 1'b1;
        endcase
      end
      ST_READ: begin
        // Read data is valid in the cycle after the request
        case (src_q)
          SRC_ROM: rd_value = rom_rdata;
          SRC_RAM: rd_value = ram_rdata;
          default: rd_value = '0;
        endcase
        finish = 1'b1;
      end
      ST_DIV: begin
        if (div_done) begin
          case (item_q.reg_select)
            SEL_SLOT0: slot0_d = new_bank;
            SEL_SLOT1: slot1_d = new_bank;
            SEL_SLOT2: slot2_d = new_bank;
            default:   ctl_d   = ctl_q;
          endcase
          finish = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Post the result for one cycle
    if (finish) begin
      done_d                        = 1'b1;
      result_d.read_data            = rd_value;
      result_d.overrides_system_ram = ctl_d[CTL_RAM_TOP];
      state_d                       = ST_IDLE;
    end

    // Configuration writes; mode change reloads the slot 2 bank
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BANK_COUNT: count_d = cfg_data_i;
        CFG_ALT_MODE: begin
          alt_d   = cfg_data_i[0];
          slot2_d = cfg_data_i[0] ? '0 : BANK_W'(2);
        end
        default: count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ctl_q   <= '0;
      slot0_q <= '0;
      slot1_q <= BANK_W'(1);
      slot2_q <= BANK_W'(2);
      count_q <= BANK_COUNT_RESET;
      alt_q   <= 1'b0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ctl_q   <= ctl_d;
      slot0_q <= slot0_d;
      slot1_q <= slot1_d;
      slot2_q <= slot2_d;
      count_q <= count_d;
      alt_q   <= alt_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Capture the accepted item; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= item_i;
    end
    result_q <= result_d;
    src_q    <= src_d;
  end

  bcm_mem #(
    .DEPTH (ROM_DEPTH),
    .AW    (ROM_AW),
    .DW    (DATA_W)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (rom_en),
    .we_i    (rom_we),
    .addr_i  (rom_addr),
    .wdata_i (rom_wdata),
    .rdata_o (rom_rdata)
  );

  bcm_mem #(
    .DEPTH (RAM_DEPTH),
    .AW    (RAM_AW),
    .DW    (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bcm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (item_q.write_data),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .remainder_o (div_rem)
  );

endmodule

`default_nettype wire

@@ hdl/bcm_mem.sv @@
// Single-port synchronous memory with registered read data.
// Used for both ROM store and cart RAM; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bcm_mem #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15,
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/bcm_div.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle over all DATA_W bits.
// Reduces bank numbers modulo the bank count; uses bcm_pkg for DATA_W.
`timescale 1ns / 1ps
`default_nettype none

module bcm_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [bcm_pkg::DATA_W-1:0] dividend_i,
  input  wire logic [bcm_pkg::DATA_W-1:0] divisor_i,
  output logic                           done_o,
  output logic      [bcm_pkg::DATA_W-1:0] remainder_o
);

  import bcm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] dvd_q, dvd_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic [DATA_W:0]   trial;

  // Shift in one dividend bit and subtract when the partial remainder allows
  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    dsr_d    = dsr_q;
    trial    = {rem_q, dvd_q[DATA_W-1]};
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      rem_d    = '0;
      dvd_d    = dividend_i;
      dsr_d    = divisor_i;
    end else if (active_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DATA_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[DATA_W-1:0];
      end
      dvd_d = {dvd_q[DATA_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (&cnt_q) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  // Datapath holds no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire
